// ===== src/jlr_pkg.sv =====
// shared types, codes and helpers for the jacobi relaxation grid
package jlr_pkg;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // cell kinds
  localparam logic [1:0] KIND_FREE   = 2'd0;
  localparam logic [1:0] KIND_PLUS   = 2'd1;
  localparam logic [1:0] KIND_MINUS  = 2'd2;
  localparam logic [1:0] KIND_GROUND = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_PLATE   = 2'd0;
  localparam logic [1:0] REG_INV     = 2'd1;
  localparam logic [1:0] REG_SWEEPS  = 2'd2;

  // register reset values
  localparam logic [14:0] PLATE_RST  = 15'd25600;
  localparam logic [15:0] INV_RST    = 16'd26214;
  localparam logic [15:0] SWEEPS_RST = 16'd1000;

  // field saturation limits
  localparam logic signed [33:0] F24_MAX = 34'sd8388607;
  localparam logic signed [33:0] F24_MIN = -34'sd8388608;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_DONE
  } jlr_state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] row;
    logic [5:0] col;
    logic [1:0] cell_kind;
  } jlr_in_t;

  typedef struct packed {
    logic signed [15:0] voltage;
    logic signed [23:0] field_x;
    logic signed [23:0] field_y;
    logic               status;
  } jlr_out_t;

  // write enables toward the grid memories
  typedef struct packed {
    logic kind_en;
    logic v0_en;
    logic v1_en;
  } jlr_wr_t;

  // round a Q18.16 product to Q16.8, then saturate to 24 bits
  function automatic logic signed [23:0] round_sat(input logic signed [33:0] p);
    logic signed [33:0] t;
    t = (p + 34'sd128) >>> 8;
    if (t > F24_MAX) begin
      return 24'sd8388607;
    end else if (t < F24_MIN) begin
      return -24'sd8388608;
    end
    return t[23:0];
  endfunction

endpackage

// ===== src/jlr_grid_mem.sv =====
// cell kind store and the two voltage banks, one read port each
module jlr_grid_mem #(
  parameter int CELL_AW = 12
) (
  input  logic                      clk_i,
  input  jlr_pkg::jlr_wr_t          wr_i,
  input  logic [CELL_AW-1:0]        wr_addr_i,
  input  logic [1:0]                wr_kind_i,
  input  logic signed [15:0]        wr_volt_i,
  input  logic [CELL_AW-1:0]        rd_addr_i,
  input  logic                      rd_bank_i,
  output logic [1:0]                rd_kind_o,
  output logic signed [15:0]        rd_volt_o
);

  localparam int Depth = 1 << CELL_AW;

  logic [1:0]         kind_mem [Depth];
  logic signed [15:0] v0_mem   [Depth];
  logic signed [15:0] v1_mem   [Depth];
  logic signed [15:0] v0_q;
  logic signed [15:0] v1_q;
  logic               bank_q;

  // writes
  always_ff @(posedge clk_i) begin
    if (wr_i.kind_en) begin
      kind_mem[wr_addr_i] <= wr_kind_i;
    end
    if (wr_i.v0_en) begin
      v0_mem[wr_addr_i] <= wr_volt_i;
    end
    if (wr_i.v1_en) begin
      v1_mem[wr_addr_i] <= wr_volt_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rd_kind_o <= kind_mem[rd_addr_i];
    v0_q      <= v0_mem[rd_addr_i];
    v1_q      <= v1_mem[rd_addr_i];
    bank_q    <= rd_bank_i;
  end

  assign rd_volt_o = bank_q ? v1_q : v0_q;

endmodule

// ===== src/jacobi_laplace_relaxation_grid_top.sv =====
// jacobi relaxation grid: command sequencer, shared adder and multiplier
//
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o  in_data_i  (jlr_in_t)
// out      output     out_valid_o / out_stall_i out_data_o (jlr_out_t)
// cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// a read makes three memory reads, then two passes through the one multiplier.
// in a run each cell needs five reads of the single-port voltage bank. after
// reset a clearing pass over all 2^(2*clog2(GRID_DIM)) addresses zeroes the
// memories; no item is taken meanwhile. in_stall_o is high whenever an item
// is in work; one finished item can wait at the output.
module jacobi_laplace_relaxation_grid_top #(
  parameter int GRID_DIM = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  jlr_pkg::jlr_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output jlr_pkg::jlr_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_wdata_i
);

  localparam int AW = $clog2(GRID_DIM);
  localparam int CELL_AW = 2 * AW;
  localparam logic [AW-1:0] LAST = AW'(GRID_DIM - 1);

  jlr_pkg::jlr_state_e state_q, state_d;

  logic [14:0]        plate_q;
  logic [15:0]        inv_q;
  logic [15:0]        sweep_q;

  logic [CELL_AW-1:0] clr_q, clr_d;
  logic [AW-1:0]      r_q, r_d, c_q, c_d;
  logic [2:0]         phase_q, phase_d;
  logic [15:0]        sweeps_q, sweeps_d;
  logic               bank_q, bank_d;
  logic               oob_q;
  logic signed [17:0] acc_q, acc_d;
  logic signed [15:0] here_q, here_d;
  logic [1:0]         kind_q, kind_d;
  logic signed [16:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [33:0] prod_q, prod_d;
  logic signed [15:0] volt_q, volt_d;
  logic signed [23:0] fx_q, fx_d, fy_q, fy_d;
  logic               stat_q, stat_d;
  jlr_pkg::jlr_out_t  out_q, out_d;
  logic               out_valid_q, out_valid_d;

  jlr_pkg::jlr_wr_t   wr;
  logic [CELL_AW-1:0] wr_addr, rd_addr;
  logic [1:0]         wr_kind, rd_kind;
  logic signed [15:0] wr_volt, rd_volt;
  logic               rd_oob;

  logic signed [15:0] nb_val;
  logic signed [17:0] sum_full;
  logic signed [17:0] avg_full;
  logic signed [16:0] mul_a;
  logic signed [33:0] prod;
  logic               in_grid;
  logic [AW-1:0]      in_r, in_c;

  jlr_grid_mem #(.CELL_AW(CELL_AW)) u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .wr_kind_i (wr_kind),
    .wr_volt_i (wr_volt),
    .rd_addr_i (rd_addr),
    .rd_bank_i (bank_q),
    .rd_kind_o (rd_kind),
    .rd_volt_o (rd_volt)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plate_q <= jlr_pkg::PLATE_RST;
      inv_q   <= jlr_pkg::INV_RST;
      sweep_q <= jlr_pkg::SWEEPS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jlr_pkg::REG_PLATE:  plate_q <= cfg_wdata_i[14:0];
        jlr_pkg::REG_INV:    inv_q   <= cfg_wdata_i;
        jlr_pkg::REG_SWEEPS: sweep_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // neighbour address for the current phase: self, left, up, down, right
  always_comb begin
    rd_addr = {r_q, c_q};
    rd_oob  = 1'b0;
    unique case (phase_q)
      3'd1: begin
        rd_addr = {r_q, c_q - AW'(1)};
        rd_oob  = (c_q == '0);
      end
      3'd2: begin
        rd_addr = {r_q - AW'(1), c_q};
        rd_oob  = (r_q == '0);
      end
      3'd3: begin
        rd_addr = {r_q + AW'(1), c_q};
        rd_oob  = (r_q == LAST);
      end
      3'd4: begin
        rd_addr = {r_q, c_q + AW'(1)};
        rd_oob  = (c_q == LAST);
      end
      default: ;
    endcase
  end

  // shared arithmetic
  assign nb_val   = oob_q ? 16'sd0 : rd_volt;
  assign sum_full = acc_q + 18'(nb_val);
  assign avg_full = (sum_full + 18'sd2) >>> 2;
  assign mul_a    = (phase_q == 3'd4) ? dx_q : dy_q;
  assign prod     = 34'(mul_a) * 34'($signed({1'b0, inv_q}));

  assign in_grid = (32'(in_data_i.row) < GRID_DIM) && (32'(in_data_i.col) < GRID_DIM);
  assign in_r    = AW'(in_data_i.row);
  assign in_c    = AW'(in_data_i.col);

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    r_d         = r_q;
    c_d         = c_q;
    phase_d     = phase_q;
    sweeps_d    = sweeps_q;
    bank_d      = bank_q;
    acc_d       = acc_q;
    here_d      = here_q;
    kind_d      = kind_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    prod_d      = prod_q;
    volt_d      = volt_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    stat_d      = stat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    wr          = '0;
    wr_addr     = {r_q, c_q};
    wr_kind     = jlr_pkg::KIND_FREE;
    wr_volt     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      jlr_pkg::ST_CLEAR: begin
        wr      = '{kind_en: 1'b1, v0_en: 1'b1, v1_en: 1'b1};
        wr_addr = clr_q;
        clr_d   = clr_q + CELL_AW'(1);
        if (clr_q == '1) begin
          state_d = jlr_pkg::ST_IDLE;
        end
      end

      jlr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          volt_d  = '0;
          fx_d    = '0;
          fy_d    = '0;
          stat_d  = 1'b0;
          phase_d = '0;
          state_d = jlr_pkg::ST_DONE;
          unique case (in_data_i.cmd)
            jlr_pkg::CMD_WRITE: begin
              if (in_grid) begin
                wr      = '{kind_en: 1'b1, v0_en: 1'b1, v1_en: 1'b1};
                wr_addr = {in_r, in_c};
                wr_kind = in_data_i.cell_kind;
                if (in_data_i.cell_kind == jlr_pkg::KIND_PLUS) begin
                  wr_volt = $signed({1'b0, plate_q});
                end else if (in_data_i.cell_kind == jlr_pkg::KIND_MINUS) begin
                  wr_volt = -$signed({1'b0, plate_q});
                end
              end else begin
                stat_d = 1'b1;
              end
            end
            jlr_pkg::CMD_RUN: begin
              r_d      = '0;
              c_d      = '0;
              sweeps_d = '0;
              if (sweep_q != '0) begin
                state_d = jlr_pkg::ST_SWEEP;
              end
            end
            jlr_pkg::CMD_READ: begin
              if (in_grid) begin
                r_d     = in_r;
                c_d     = in_c;
                state_d = jlr_pkg::ST_READ;
              end else begin
                stat_d = 1'b1;
              end
            end
            default: stat_d = 1'b1;
          endcase
        end
      end

      jlr_pkg::ST_SWEEP: begin
        phase_d = phase_q + 3'd1;
        if (phase_q == 3'd1) begin
          here_d = nb_val;
          kind_d = rd_kind;
          acc_d  = '0;
        end else if (phase_q >= 3'd2 && phase_q <= 3'd4) begin
          acc_d = sum_full;
        end else if (phase_q == 3'd5) begin
          // write the new value into the other bank
          wr.v0_en = bank_q;
          wr.v1_en = !bank_q;
          wr_volt  = (kind_q == jlr_pkg::KIND_FREE) ? avg_full[15:0] : here_q;
          phase_d  = '0;
          if (c_q == LAST) begin
            c_d = '0;
            if (r_q == LAST) begin
              r_d      = '0;
              bank_d   = !bank_q;
              sweeps_d = sweeps_q + 16'd1;
              if (sweeps_q + 16'd1 == sweep_q) begin
                state_d = jlr_pkg::ST_DONE;
              end
            end else begin
              r_d = r_q + AW'(1);
            end
          end else begin
            c_d = c_q + AW'(1);
          end
        end
      end

      jlr_pkg::ST_READ: begin
        phase_d = phase_q + 3'd1;
        unique case (phase_q)
          3'd1: begin
            here_d = nb_val;
            kind_d = rd_kind;
          end
          3'd2: dx_d = 17'(nb_val) - 17'(here_q);
          3'd3: dy_d = 17'(nb_val) - 17'(here_q);
          3'd4: prod_d = prod;
          3'd5: begin
            fx_d   = jlr_pkg::round_sat(prod_q);
            prod_d = prod;
          end
          3'd6: begin
            volt_d  = here_q;
            fy_d    = jlr_pkg::round_sat(prod_q);
            if (kind_q == jlr_pkg::KIND_GROUND) begin
              fx_d = '0;
              fy_d = '0;
            end
            state_d = jlr_pkg::ST_DONE;
          end
          default: ;
        endcase
      end

      jlr_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = '{voltage: volt_q, field_x: fx_q, field_y: fy_q, status: stat_q};
          out_valid_d = 1'b1;
          state_d     = jlr_pkg::ST_IDLE;
        end
      end

      default: state_d = jlr_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jlr_pkg::ST_CLEAR;
      clr_q       <= '0;
      phase_q     <= '0;
      sweeps_q    <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      phase_q     <= phase_d;
      sweeps_q    <= sweeps_d;
      bank_q      <= bank_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    c_q    <= c_d;
    oob_q  <= rd_oob;
    acc_q  <= acc_d;
    here_q <= here_d;
    kind_q <= kind_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    prod_q <= prod_d;
    volt_q <= volt_d;
    fx_q   <= fx_d;
    fy_q   <= fy_d;
    stat_q <= stat_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != jlr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
